// File: design/dsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsa_pkg
// Shared constants, codes, payload types and helpers for the descriptor slot
// allocator.
// ----------------------------------------------------------------------------
package dsa_pkg;

    // Built capacity and frame count
    localparam int CAPACITY  = 1024;
    localparam int FRAMES    = 3;

    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int FRM_IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int DEF_DEPTH = FRAMES * CAPACITY;
    localparam int DEF_AW    = $clog2(DEF_DEPTH);

    // Field and register widths
    localparam int ADDR_W     = 48;
    localparam int STRIDE_W   = 13;
    localparam int HSIZE_W    = 11;
    localparam int CMD_W      = 2;
    localparam int FRAME_W    = 2;
    localparam int SLOT_W     = 10;
    localparam int RECL_W     = 11;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // Divider: quotient range reaches past the capacity
    localparam int QUOT_W = CNT_W;
    localparam int REM_W  = QUOT_W + STRIDE_W;
    localparam int OFF_W  = IDX_W + STRIDE_W;

    // Register reset values
    localparam int HEAP_SIZE_RST = 1024;
    localparam int STRIDE_RST    = 32;

    // Commands
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DRAIN = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_SIZE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CPU_BASE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GPU_BASE       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHADER_VISIBLE = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [ADDR_W-1:0]  handle_cpu_address;
        logic [FRAME_W-1:0] frame_slot;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   cpu_address;
        logic [ADDR_W-1:0]   gpu_address;
        logic [SLOT_W-1:0]   slot_index;
        logic [RECL_W-1:0]   reclaimed_count;
        logic [STATUS_W-1:0] status;
    } out_item_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quotient;
        logic              rem_zero;
    } div_out_t;

    // Deferred store address: one row of CAPACITY entries per frame
    function automatic logic [DEF_AW-1:0] def_addr(input logic [FRM_IDX_W-1:0] frame,
                                                   input logic [IDX_W-1:0] pos);
        def_addr = DEF_AW'(frame) * DEF_AW'(CAPACITY) + DEF_AW'(pos);
    endfunction

endpackage

// File: design/dsa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsa_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module dsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/dsa_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsa_div
// Restoring divider, one quotient bit per cycle. Turns a handle offset into
// a slot index and reports whether the offset sits on a stride boundary.
// ----------------------------------------------------------------------------
module dsa_div
    import dsa_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [REM_W-1:0]    dividend,
    input  logic [STRIDE_W-1:0] divisor,
    output div_out_t            result
);

    localparam int STEP_W = $clog2(QUOT_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [REM_W-1:0]  rem_reg,  rem_next;
    logic [REM_W-1:0]  den_reg,  den_next;
    logic [QUOT_W-1:0] quot_reg, quot_next;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        if (start) begin
            // dividend is known to be below divisor * 2^QUOT_W
            rem_next  = dividend;
            den_next  = REM_W'({divisor, {(QUOT_W - 1){1'b0}}});
            quot_next = '0;
            step_next = STEP_W'(QUOT_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_reg >= den_reg) begin
                rem_next  = rem_reg - den_reg;
                quot_next = {quot_reg[QUOT_W-2:0], 1'b1};
            end else begin
                quot_next = {quot_reg[QUOT_W-2:0], 1'b0};
            end
            den_next  = den_reg >> 1;
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        step_reg <= step_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign result.done     = done_reg;
    assign result.quotient = quot_reg;
    assign result.rem_zero = (rem_reg == '0);

endmodule

// File: design/descriptor_slot_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// descriptor_slot_allocator_unit
// Slot allocator over a stack of free indices with per-frame deferred frees.
// ----------------------------------------------------------------------------
// One item is worked at a time; s_ready is high only between items, and a
// finished result waits in the output register while the next item runs.
// After acceptance, allocate runs the free-stack read, the index times stride
// multiply and the 48-bit base add; an error found at acceptance (full heap,
// zero handle, handle below base, bad frame, unknown command) goes straight to
// the result; free waits on the one-bit-per-cycle divider that turns an
// address into a slot index, unless the handle lies past any possible slot
// and is rejected before dividing; drain pushes the frame's deferred entries
// back, one stack write per cycle from the deferred-store read port. A result
// that waits on m_ready adds its stall.
// The free stack and the deferred lists live in two RAMs. No clearing pass
// follows reset: a high-water mark makes every stack entry never written read
// as its own index.
// ----------------------------------------------------------------------------
module descriptor_slot_allocator_unit
    import dsa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_item
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC_RD,
        S_ALLOC_ADD,
        S_FREE_RANGE,
        S_FREE_DIV,
        S_DRAIN_INIT,
        S_DRAIN,
        S_DONE
    } state_t;

    // Configuration registers
    logic [HSIZE_W-1:0]  heap_size_reg;
    logic [STRIDE_W-1:0] stride_reg;
    logic [ADDR_W-1:0]   cpu_base_reg;
    logic [ADDR_W-1:0]   gpu_base_reg;
    logic                shader_visible_reg;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     used_reg, used_next;
    logic [CNT_W-1:0]     hw_reg, hw_next;
    logic [CNT_W-1:0]     pend_total_reg, pend_total_next;
    logic [CNT_W-1:0]     dcount_reg [FRAMES];
    logic [CNT_W-1:0]     dcount_next [FRAMES];
    logic [FRM_IDX_W-1:0] frame_reg, frame_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [OFF_W-1:0]     off_reg, off_next;
    logic [ADDR_W-1:0]    diff_reg, diff_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [CNT_W-1:0]     full_cnt_reg, full_cnt_next;
    logic [CNT_W-1:0]     rd_i_reg, rd_i_next;
    logic                 rd_pend_reg, rd_pend_next;
    out_item_t            res_reg, res_next;
    logic                 m_valid_reg, m_valid_next;
    out_item_t            m_item_reg, m_item_next;

    logic [CNT_W-1:0]     eff_size;
    logic [STRIDE_W-1:0]  eff_stride;
    logic [CNT_W-1:0]     cur_count;
    logic                 frame_bad;
    logic [IDX_W-1:0]     pop_idx;

    logic                 stack_we;
    logic [IDX_W-1:0]     stack_rdata;
    logic                 def_we;
    logic [IDX_W-1:0]     def_rdata;
    logic                 div_start;
    div_out_t             div_res;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_size_reg      <= HSIZE_W'(HEAP_SIZE_RST);
            stride_reg         <= STRIDE_W'(STRIDE_RST);
            cpu_base_reg       <= '0;
            gpu_base_reg       <= '0;
            shader_visible_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_HEAP_SIZE:      heap_size_reg      <= cfg_data[HSIZE_W-1:0];
                REG_STRIDE:         stride_reg         <= cfg_data[STRIDE_W-1:0];
                REG_CPU_BASE:       cpu_base_reg       <= cfg_data[ADDR_W-1:0];
                REG_GPU_BASE:       gpu_base_reg       <= cfg_data[ADDR_W-1:0];
                REG_SHADER_VISIBLE: shader_visible_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign eff_size   = (32'(heap_size_reg) > CAPACITY) ? CNT_W'(CAPACITY)
                                                        : CNT_W'(heap_size_reg);
    assign eff_stride = (stride_reg == '0) ? STRIDE_W'(1) : stride_reg;
    assign cur_count  = dcount_reg[frame_reg];
    assign frame_bad  = (32'(s_item.frame_slot) >= FRAMES);

    // Entries at or above the high-water mark were never written
    assign pop_idx = (used_reg >= hw_reg) ? used_reg[IDX_W-1:0] : stack_rdata;

    // ------------------------------------------------------------------
    // Storage
    // ------------------------------------------------------------------
    dsa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (CAPACITY)
    ) u_free_stack (
        .aclk  (aclk),
        .we    (stack_we),
        .waddr (IDX_W'(used_reg - CNT_W'(1))),
        .wdata (def_rdata),
        .raddr (used_reg[IDX_W-1:0]),
        .rdata (stack_rdata)
    );

    dsa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (DEF_DEPTH)
    ) u_deferred (
        .aclk  (aclk),
        .we    (def_we),
        .waddr (def_addr(frame_reg, cur_count[IDX_W-1:0])),
        .wdata (IDX_W'(div_res.quotient)),
        .raddr (def_addr(frame_reg, rd_i_reg[IDX_W-1:0])),
        .rdata (def_rdata)
    );

    dsa_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (REM_W'(diff_reg)),
        .divisor  (eff_stride),
        .result   (div_res)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next      = state_reg;
        used_next       = used_reg;
        hw_next         = hw_reg;
        pend_total_next = pend_total_reg;
        dcount_next     = dcount_reg;
        frame_next      = frame_reg;
        idx_next        = idx_reg;
        off_next        = off_reg;
        diff_next       = diff_reg;
        n_next          = n_reg;
        full_cnt_next   = full_cnt_reg;
        rd_i_next       = rd_i_reg;
        rd_pend_next    = rd_pend_reg;
        res_next        = res_reg;
        m_valid_next    = m_valid_reg;
        m_item_next     = m_item_reg;
        stack_we        = 1'b0;
        def_we          = 1'b0;
        div_start       = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    res_next   = '0;
                    frame_next = FRM_IDX_W'(s_item.frame_slot);
                    case (s_item.command)
                        CMD_ALLOC: begin
                            if (used_reg >= eff_size) begin
                                res_next.status = ST_FULL;
                                state_next      = S_DONE;
                            end else begin
                                state_next = S_ALLOC_RD;
                            end
                        end
                        CMD_FREE: begin
                            if (s_item.handle_cpu_address == '0) begin
                                res_next.status = ST_INVALID;
                                state_next      = S_DONE;
                            end else if (frame_bad ||
                                         s_item.handle_cpu_address < cpu_base_reg) begin
                                res_next.status = ST_RANGE;
                                state_next      = S_DONE;
                            end else begin
                                diff_next  = s_item.handle_cpu_address - cpu_base_reg;
                                state_next = S_FREE_RANGE;
                            end
                        end
                        CMD_DRAIN: begin
                            if (frame_bad) begin
                                res_next.status = ST_RANGE;
                                state_next      = S_DONE;
                            end else begin
                                state_next = S_DRAIN_INIT;
                            end
                        end
                        default: begin
                            res_next.status = ST_INVALID;
                            state_next      = S_DONE;
                        end
                    endcase
                end
            end

            S_ALLOC_RD: begin
                idx_next   = pop_idx;
                off_next   = OFF_W'(pop_idx) * OFF_W'(eff_stride);
                state_next = S_ALLOC_ADD;
            end

            S_ALLOC_ADD: begin
                res_next.cpu_address = cpu_base_reg + ADDR_W'(off_reg);
                if (shader_visible_reg) begin
                    res_next.gpu_address = gpu_base_reg + ADDR_W'(off_reg);
                end
                res_next.slot_index = SLOT_W'(idx_reg);
                used_next           = used_reg + CNT_W'(1);
                if (used_reg >= hw_reg) begin
                    hw_next = used_reg + CNT_W'(1);
                end
                state_next = S_DONE;
            end

            S_FREE_RANGE: begin
                // Index would be past any size: reject before dividing
                if (diff_reg >= (ADDR_W'(eff_stride) << QUOT_W)) begin
                    res_next.status = ST_RANGE;
                    state_next      = S_DONE;
                end else begin
                    div_start  = 1'b1;
                    state_next = S_FREE_DIV;
                end
            end

            S_FREE_DIV: begin
                if (div_res.done) begin
                    if (!div_res.rem_zero || div_res.quotient >= eff_size ||
                        pend_total_reg >= used_reg) begin
                        res_next.status = ST_RANGE;
                    end else begin
                        res_next.slot_index = SLOT_W'(div_res.quotient);
                        if (cur_count < CNT_W'(CAPACITY)) begin
                            def_we                 = 1'b1;
                            dcount_next[frame_reg] = cur_count + CNT_W'(1);
                            pend_total_next        = pend_total_reg + CNT_W'(1);
                        end
                    end
                    state_next = S_DONE;
                end
            end

            S_DRAIN_INIT: begin
                n_next        = (cur_count < used_reg) ? cur_count : used_reg;
                full_cnt_next = cur_count;
                rd_i_next     = '0;
                rd_pend_next  = 1'b0;
                state_next    = S_DRAIN;
            end

            S_DRAIN: begin
                // Push the entry read last cycle
                if (rd_pend_reg) begin
                    stack_we  = 1'b1;
                    used_next = used_reg - CNT_W'(1);
                end
                if (rd_i_reg < n_reg) begin
                    rd_i_next    = rd_i_reg + CNT_W'(1);
                    rd_pend_next = 1'b1;
                end else begin
                    rd_pend_next = 1'b0;
                    if (!rd_pend_reg) begin
                        dcount_next[frame_reg]   = '0;
                        pend_total_next          = pend_total_reg - full_cnt_reg;
                        res_next.reclaimed_count = RECL_W'(n_reg);
                        state_next               = S_DONE;
                    end
                end
            end

            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_item_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        frame_reg    <= frame_next;
        idx_reg      <= idx_next;
        off_reg      <= off_next;
        diff_reg     <= diff_next;
        n_reg        <= n_next;
        full_cnt_reg <= full_cnt_next;
        rd_i_reg     <= rd_i_next;
        res_reg      <= res_next;
        m_item_reg   <= m_item_next;
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            hw_reg         <= '0;
            pend_total_reg <= '0;
            rd_pend_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
            for (int f = 0; f < FRAMES; f++) begin
                dcount_reg[f] <= '0;
            end
        end else begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            hw_reg         <= hw_next;
            pend_total_reg <= pend_total_next;
            rd_pend_reg    <= rd_pend_next;
            m_valid_reg    <= m_valid_next;
            dcount_reg     <= dcount_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

// File: design/dsa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsa_checker
// Port-level checks for the descriptor slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module dsa_checker
    import dsa_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input out_item_t             m_item
);

    // One item at a time: ready drops right after an item is taken
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is in progress");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("stalled result changed or dropped");

    // Any error leaves the address and count fields clear
    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.status != ST_OK |->
            m_item.cpu_address == '0 && m_item.gpu_address == '0 &&
            m_item.reclaimed_count == '0)
        else $error("error result carries data");

    // Only a drain reports reclaimed slots, and a drain reports no slot
    a_drain_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.reclaimed_count != '0 |->
            m_item.status == ST_OK && m_item.cpu_address == '0 &&
            m_item.slot_index == '0)
        else $error("drain result mixed with allocation fields");

endmodule

bind descriptor_slot_allocator_unit dsa_checker u_dsa_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_item    (m_item)
);

// File: tb/dsa_reply_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsa_reply_checker
// Watches the configuration port and both item channels of the slot
// allocator. Keeps its own copy of the free stack, the used count and the
// per-frame deferred lists, works out the reply to every accepted item and
// compares each delivered reply, field by field, against the oldest one owed.
// ----------------------------------------------------------------------------
module dsa_reply_checker
    import dsa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_item_t              s_item,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_item_t             m_item,
    output int                    fail_count,
    output int                    outstanding
);

    logic [HSIZE_W-1:0]  heap_size_r;
    logic [STRIDE_W-1:0] stride_r;
    logic [ADDR_W-1:0]   cpu_base_r;
    logic [ADDR_W-1:0]   gpu_base_r;
    logic                visible_r;

    logic [IDX_W-1:0] free_slots [CAPACITY];
    int unsigned      slots_out;
    logic [IDX_W-1:0] deferred_slots [FRAMES][CAPACITY];
    int unsigned      deferred_len [FRAMES];

    out_item_t heap_replies_q [$];

    // Apply one command to the heap copy and return the reply it earns.
    function automatic out_item_t heap_reply(input in_item_t it);
        out_item_t         r;
        int unsigned       size_eff;
        int unsigned       queued;
        int unsigned       f;
        int unsigned       k;
        logic [ADDR_W-1:0] step;
        logic [ADDR_W-1:0] off;
        logic [ADDR_W-1:0] diff;
        logic [ADDR_W-1:0] idx;
        r = '0;
        size_eff = (heap_size_r < CAPACITY) ? heap_size_r : CAPACITY;
        step = (stride_r == '0) ? ADDR_W'(1) : ADDR_W'(stride_r);
        queued = 0;
        for (k = 0; k < FRAMES; k++) begin
            queued += deferred_len[k];
        end
        case (it.command)
            CMD_ALLOC: begin
                if (slots_out >= size_eff) begin
                    r.status = ST_FULL;
                end else begin
                    off = ADDR_W'(free_slots[slots_out]) * step;
                    r.slot_index = free_slots[slots_out];
                    r.cpu_address = cpu_base_r + off;
                    if (visible_r) begin
                        r.gpu_address = gpu_base_r + off;
                    end
                    slots_out++;
                end
            end
            CMD_FREE: begin
                if (it.handle_cpu_address == '0) begin
                    r.status = ST_INVALID;
                end else if (it.frame_slot >= FRAMES
                             || it.handle_cpu_address < cpu_base_r) begin
                    r.status = ST_RANGE;
                end else begin
                    diff = it.handle_cpu_address - cpu_base_r;
                    idx = diff / step;
                    // refuse once the deferred lists cover every slot in use
                    if (diff % step != '0 || idx >= size_eff || queued >= slots_out) begin
                        r.status = ST_RANGE;
                    end else begin
                        f = it.frame_slot;
                        deferred_slots[f][deferred_len[f]] = idx[IDX_W-1:0];
                        deferred_len[f]++;
                        r.slot_index = idx[SLOT_W-1:0];
                    end
                end
            end
            CMD_DRAIN: begin
                if (it.frame_slot >= FRAMES) begin
                    r.status = ST_RANGE;
                end else begin
                    f = it.frame_slot;
                    // push back in list order, top of the used region first
                    for (k = 0; k < deferred_len[f] && slots_out != 0; k++) begin
                        slots_out--;
                        free_slots[slots_out] = deferred_slots[f][k];
                        r.reclaimed_count = r.reclaimed_count + 1'b1;
                    end
                    deferred_len[f] = 0;
                end
            end
            default: begin
                r.status = ST_INVALID;
            end
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin : score
        out_item_t   want;
        int unsigned i;
        if (!aresetn) begin
            heap_size_r = HSIZE_W'(HEAP_SIZE_RST);
            stride_r = STRIDE_W'(STRIDE_RST);
            cpu_base_r = '0;
            gpu_base_r = '0;
            visible_r = 1'b0;
            for (i = 0; i < CAPACITY; i++) begin
                free_slots[i] = IDX_W'(i);
            end
            slots_out = 0;
            for (i = 0; i < FRAMES; i++) begin
                deferred_len[i] = 0;
            end
            heap_replies_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (heap_replies_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: reply with none owed: cpu %h gpu %h slot %0d recl %0d st %0d",
                                 $realtime, m_item.cpu_address, m_item.gpu_address,
                                 m_item.slot_index, m_item.reclaimed_count, m_item.status);
                    end
                end else begin
                    want = heap_replies_q.pop_front();
                    if (m_item.cpu_address !== want.cpu_address
                        || m_item.gpu_address !== want.gpu_address
                        || m_item.slot_index !== want.slot_index
                        || m_item.reclaimed_count !== want.reclaimed_count
                        || m_item.status !== want.status) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: reply mismatch (expected / actual)", $realtime);
                            $display("  cpu %h / %h  gpu %h / %h", want.cpu_address,
                                     m_item.cpu_address, want.gpu_address, m_item.gpu_address);
                            $display("  slot %0d / %0d  recl %0d / %0d  status %0d / %0d",
                                     want.slot_index, m_item.slot_index, want.reclaimed_count,
                                     m_item.reclaimed_count, want.status, m_item.status);
                        end
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_HEAP_SIZE:      heap_size_r = cfg_data[HSIZE_W-1:0];
                    REG_STRIDE:         stride_r = cfg_data[STRIDE_W-1:0];
                    REG_CPU_BASE:       cpu_base_r = cfg_data[ADDR_W-1:0];
                    REG_GPU_BASE:       gpu_base_r = cfg_data[ADDR_W-1:0];
                    REG_SHADER_VISIBLE: visible_r = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                // append at the tail of the owed list
                heap_replies_q.insert(heap_replies_q.size(), heap_reply(s_item));
            end
        end
        outstanding <= heap_replies_q.size();
    end

endmodule

// File: tb/descriptor_slot_allocator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// descriptor_slot_allocator_unit_tb
// Runs directed corner cases (full heap, zero size and stride, bad handles,
// bad frames, refused frees, empty drains, unknown command) and then random
// allocate/free/drain traffic under several heap settings and handshake
// pressure. Replies are scored by dsa_reply_checker.
// ----------------------------------------------------------------------------
module descriptor_slot_allocator_unit_tb;
    import dsa_pkg::*;

    localparam logic [CMD_W-1:0]   CMD_UNUSED       = 2'd3;
    localparam logic [FRAME_W-1:0] FRAME_BAD        = FRAME_W'(FRAMES);
    localparam int                 DIR_STRIDE       = 8191;
    localparam int                 NUM_PHASES       = 6;
    localparam int                 RANDOM_PER_PHASE = 235;
    localparam longint             CYCLE_LIMIT      = 1_000_000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_item = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_item;

    int     fail_count;
    int     outstanding;
    int     tx_idle_pct = 0;
    int     rx_stall_pct = 0;
    longint cycle_count = 0;

    // heap settings as last written, used to aim frees at real slots
    int unsigned       cur_size;
    logic [ADDR_W-1:0] cur_step;
    logic [ADDR_W-1:0] cur_cpu_base;

    descriptor_slot_allocator_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    dsa_reply_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL descriptor_slot_allocator_unit");
            $finish;
        end
    end

    function automatic logic [ADDR_W-1:0] rand48();
        return ADDR_W'({$urandom, $urandom});
    endfunction

    function automatic in_item_t heap_cmd(input logic [CMD_W-1:0] cmd,
                                          input logic [ADDR_W-1:0] handle,
                                          input logic [FRAME_W-1:0] frame);
        return '{command: cmd, handle_cpu_address: handle, frame_slot: frame};
    endfunction

    // Mostly allocates and well-aimed frees, with drains and a share of junk.
    function automatic in_item_t random_item();
        in_item_t          it;
        int unsigned       pick;
        int unsigned       k;
        logic [ADDR_W-1:0] slot_addr;
        k = $urandom_range((cur_size == 0) ? 0 : cur_size - 1);
        slot_addr = cur_cpu_base + ADDR_W'(k) * cur_step;
        it.handle_cpu_address = rand48();
        it.frame_slot = ($urandom_range(9) == 0) ? FRAME_BAD
                                                 : FRAME_W'($urandom_range(FRAMES - 1));
        pick = $urandom_range(99);
        if (pick < 45) begin
            it.command = CMD_ALLOC;
        end else if (pick < 80) begin
            it.command = CMD_FREE;
            case ($urandom_range(9))
                0: it.handle_cpu_address = '0;
                1: ;
                2: it.handle_cpu_address = slot_addr
                                           + ADDR_W'(1 + $urandom_range(int'(cur_step) - 1));
                3: it.handle_cpu_address = cur_cpu_base - ADDR_W'(1 + $urandom_range(15));
                4: it.handle_cpu_address = cur_cpu_base
                                           + ADDR_W'(cur_size + $urandom_range(3)) * cur_step;
                default: it.handle_cpu_address = slot_addr;
            endcase
        end else if (pick < 96) begin
            it.command = CMD_DRAIN;
        end else begin
            it.command = CMD_UNUSED;
        end
        return it;
    endfunction

    task automatic program_heap(input int unsigned size, input int unsigned stride,
                                input logic [ADDR_W-1:0] cpu, input logic [ADDR_W-1:0] gpu,
                                input logic vis);
        cfg_we <= 1'b1;
        cfg_index <= REG_HEAP_SIZE;
        cfg_data <= CFG_DATA_W'(size);
        @(posedge aclk);
        cfg_index <= REG_STRIDE;
        cfg_data <= CFG_DATA_W'(stride);
        @(posedge aclk);
        cfg_index <= REG_CPU_BASE;
        cfg_data <= CFG_DATA_W'(cpu);
        @(posedge aclk);
        cfg_index <= REG_GPU_BASE;
        cfg_data <= CFG_DATA_W'(gpu);
        @(posedge aclk);
        cfg_index <= REG_SHADER_VISIBLE;
        cfg_data <= CFG_DATA_W'(vis);
        @(posedge aclk);
        cfg_we <= 1'b0;
        cur_size = (size < CAPACITY) ? size : CAPACITY;
        cur_step = (stride == 0) ? ADDR_W'(1) : ADDR_W'(stride);
        cur_cpu_base = cpu;
    endtask

    // Optional idle gap, then present the item and hold it until accepted.
    // Valid is left high on return so back-to-back items never toggle it.
    task automatic send_item(input in_item_t it);
        int n;
        n = 0;
        while ($urandom_range(99) < tx_idle_pct) begin
            n++;
        end
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_item <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (8) @(posedge aclk);
    endtask

    initial begin : stimulus
        logic [ADDR_W-1:0] b;
        int                ph;
        int                n;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // three slots, widest stride, bases near the top so the GPU side wraps
        b = 48'hFFFF_FFFF_0000;
        program_heap(3, DIR_STRIDE, b, '1, 1'b1);
        send_item(heap_cmd(CMD_FREE, b, 0));                        // nothing in use
        send_item(heap_cmd(CMD_ALLOC, '0, 0));
        send_item(heap_cmd(CMD_ALLOC, '1, 3));
        send_item(heap_cmd(CMD_ALLOC, '0, 0));
        send_item(heap_cmd(CMD_ALLOC, '0, 0));                       // heap full
        send_item(heap_cmd(CMD_FREE, '0, 0));                        // zero handle
        send_item(heap_cmd(CMD_FREE, b + DIR_STRIDE, FRAME_BAD));
        send_item(heap_cmd(CMD_FREE, b + 1, 0));                     // off the grid
        send_item(heap_cmd(CMD_FREE, b - 1, 0));                     // below base
        send_item(heap_cmd(CMD_FREE, b + 3 * DIR_STRIDE, 0));        // past the heap
        send_item(heap_cmd(CMD_FREE, b + DIR_STRIDE, 0));
        send_item(heap_cmd(CMD_FREE, b, 1));
        send_item(heap_cmd(CMD_FREE, b + 2 * DIR_STRIDE, 2));
        send_item(heap_cmd(CMD_FREE, b, 0));                         // all slots queued
        send_item(heap_cmd(CMD_DRAIN, '0, FRAME_BAD));
        send_item(heap_cmd(CMD_DRAIN, '0, 0));
        send_item(heap_cmd(CMD_DRAIN, '0, 0));                       // already empty
        send_item(heap_cmd(CMD_UNUSED, '1, FRAME_BAD));
        send_item(heap_cmd(CMD_DRAIN, '0, 1));
        send_item(heap_cmd(CMD_DRAIN, '0, 2));
        send_item(heap_cmd(CMD_ALLOC, '0, 0));
        send_item(heap_cmd(CMD_FREE, '1, 2));
        wait_drained();

        // zero size and zero stride
        program_heap(0, 0, '0, '0, 1'b0);
        send_item(heap_cmd(CMD_ALLOC, '0, 0));
        send_item(heap_cmd(CMD_FREE, 48'd1, 0));
        send_item(heap_cmd(CMD_DRAIN, '0, 0));
        wait_drained();

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 0;
                    program_heap(1024, 32, rand48(), rand48(), 1'b1);
                end
                1: begin
                    tx_idle_pct = 81;
                    rx_stall_pct = 0;
                    program_heap(16, 4096, rand48(), rand48(), 1'b0);
                end
                2: begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 81;
                    program_heap(2047, 1, '0, '1, 1'b1);
                end
                3: begin
                    tx_idle_pct = 35;
                    rx_stall_pct = 35;
                    program_heap(7, 0, rand48(), rand48(), 1'b1);
                end
                4: begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 0;
                    program_heap(1, 8191, rand48(), rand48(), 1'($urandom_range(1)));
                end
                default: begin
                    tx_idle_pct = 35;
                    rx_stall_pct = 35;
                    program_heap($urandom_range(1, 1024), $urandom_range(1, 4096),
                                 rand48(), rand48(), 1'b1);
                end
            endcase
            for (n = 0; n < RANDOM_PER_PHASE; n++) begin
                // now and then let everything settle before going on
                if ($urandom_range(63) == 0) begin
                    wait_drained();
                end
                send_item(random_item());
            end
            wait_drained();
        end

        repeat (32) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("PASS descriptor_slot_allocator_unit");
        end else begin
            $display("FAIL descriptor_slot_allocator_unit");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/dsa_pkg.sv
design/dsa_ram.sv
design/dsa_div.sv
design/descriptor_slot_allocator_unit.sv
design/dsa_checker.sv
tb/dsa_reply_checker.sv
tb/descriptor_slot_allocator_unit_tb.sv
